/* hw/rtl/grouped_round_robin_task_picker_unit_macros.svh */
// ----------------------------------------------------------------------------
// Grouped round robin task picker assertion macros
// Shared concurrent assertion forms for the task picker RTL.
// ----------------------------------------------------------------------------
`ifndef GROUPED_ROUND_ROBIN_TASK_PICKER_UNIT_MACROS_SVH
`define GROUPED_ROUND_ROBIN_TASK_PICKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRRTP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("task picker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRRTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("task picker assertion failed");

`endif

/* hw/rtl/grrtp_pkg.sv */
// ----------------------------------------------------------------------------
// Grouped round robin task picker package
// Shared types, sizes and group codes for the task picker.
// ----------------------------------------------------------------------------
package grrtp_pkg;

  localparam int PlayerSlots = 5;
  localparam int HelperSlots = 15;
  localparam int PtrPW = $clog2(PlayerSlots);
  localparam int PtrHW = $clog2(HelperSlots);
  localparam int IdxW = (PtrHW > PtrPW) ? PtrHW : PtrPW;
  localparam int SlotW = 4;
  localparam int GrpW = 2;

  typedef enum logic [GrpW-1:0] {
    GrpA = 2'd0,
    GrpB = 2'd1,
    GrpH = 2'd2
  } grp_e;

  typedef struct packed {
    logic [PlayerSlots-1:0] alive_a;
    logic [PlayerSlots-1:0] alive_b;
    logic [HelperSlots-1:0] alive_h;
  } grrtp_in_t;

  typedef struct packed {
    logic             found;
    logic [GrpW-1:0]  chosen_group;
    logic [SlotW-1:0] chosen_slot;
  } grrtp_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
    logic miss;
  } grrtp_cmd_t;

  typedef struct packed {
    logic none_live;
    logic hit;
  } grrtp_sts_t;

endpackage

/* hw/rtl/grrtp_ctrl.sv */
// ----------------------------------------------------------------------------
// Task picker controller
// Sequences capture, group selection, the serial slot scan and the result word.
// ----------------------------------------------------------------------------
module grrtp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  grrtp_pkg::grrtp_sts_t sts_i,
  output grrtp_pkg::grrtp_cmd_t cmd_o
);
  import grrtp_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StPick,
    StScan
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   res_free;

  always_comb begin
    cmd_o    = '0;
    res_free = !out_valid_q || !out_stall_i;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
      end
      StPick: begin
        if (!sts_i.none_live) begin
          cmd_o.start = 1'b1;
        end else if (res_free) begin
          cmd_o.miss = 1'b1;
        end
      end
      StScan: begin
        if (sts_i.hit) begin
          cmd_o.commit = res_free;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit || cmd_o.miss) begin
        out_valid_q <= 1'b1;
      end else begin
        out_valid_q <= out_valid_q && out_stall_i;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StPick;
          end
        end
        StPick: begin
          if (cmd_o.start) begin
            state_q <= StScan;
          end else if (cmd_o.miss) begin
            state_q <= StIdle;
          end
        end
        StScan: begin
          if (cmd_o.commit) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/grrtp_dp.sv */
// ----------------------------------------------------------------------------
// Task picker datapath
// Holds the live masks, group pointers, scan index and the result word.
// ----------------------------------------------------------------------------
module grrtp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grrtp_pkg::grrtp_in_t  in_data_i,
  input  grrtp_pkg::grrtp_cmd_t cmd_i,
  output grrtp_pkg::grrtp_sts_t sts_o,
  output grrtp_pkg::grrtp_out_t out_data_o
);
  import grrtp_pkg::*;

  grrtp_in_t   mask_q;
  grp_e        cur_grp_q;
  grp_e        scan_grp_q;
  logic [PtrPW-1:0] ptr_a_q;
  logic [PtrPW-1:0] ptr_b_q;
  logic [PtrHW-1:0] ptr_h_q;
  logic [IdxW-1:0]  idx_q;
  grrtp_out_t  res_q;

  grp_e            next_grp;
  grp_e            tgt_grp;
  logic [IdxW-1:0] base;
  logic [IdxW-1:0] start_lim;
  logic [IdxW-1:0] start_idx;
  logic [IdxW-1:0] scan_lim;
  logic [IdxW-1:0] step_idx;
  logic            live_bit;

  always_comb begin
    unique case (cur_grp_q)
      GrpA:    next_grp = (|mask_q.alive_b) ? GrpB : GrpH;
      GrpB:    next_grp = GrpH;
      GrpH:    next_grp = (|mask_q.alive_a) ? GrpA : GrpB;
      default: next_grp = GrpA;
    endcase

    if (next_grp == GrpA && (|mask_q.alive_a)) begin
      tgt_grp = GrpA;
    end else if (next_grp == GrpB && (|mask_q.alive_b)) begin
      tgt_grp = GrpB;
    end else begin
      tgt_grp = GrpH;
    end
    sts_o.none_live = (tgt_grp == GrpH) && !(|mask_q.alive_h);

    unique case (tgt_grp)
      GrpA:    base = IdxW'(ptr_a_q);
      GrpB:    base = IdxW'(ptr_b_q);
      default: base = IdxW'(ptr_h_q);
    endcase
    start_lim = (tgt_grp == GrpH) ? IdxW'(HelperSlots - 1) : IdxW'(PlayerSlots - 1);
    start_idx = (base == start_lim) ? '0 : base + IdxW'(1);

    scan_lim = (scan_grp_q == GrpH) ? IdxW'(HelperSlots - 1) : IdxW'(PlayerSlots - 1);
    step_idx = (idx_q == scan_lim) ? '0 : idx_q + IdxW'(1);

    unique case (scan_grp_q)
      GrpA:    live_bit = mask_q.alive_a[idx_q[PtrPW-1:0]];
      GrpB:    live_bit = mask_q.alive_b[idx_q[PtrPW-1:0]];
      default: live_bit = mask_q.alive_h[idx_q[PtrHW-1:0]];
    endcase
    sts_o.hit = live_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_grp_q  <= GrpH;
      scan_grp_q <= GrpH;
      ptr_a_q    <= '0;
      ptr_b_q    <= '0;
      ptr_h_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.start) begin
        scan_grp_q <= tgt_grp;
        idx_q      <= start_idx;
      end else if (cmd_i.step) begin
        idx_q <= step_idx;
      end
      if (cmd_i.commit) begin
        cur_grp_q <= scan_grp_q;
        unique case (scan_grp_q)
          GrpA:    ptr_a_q <= idx_q[PtrPW-1:0];
          GrpB:    ptr_b_q <= idx_q[PtrPW-1:0];
          default: ptr_h_q <= idx_q[PtrHW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      res_q.found        <= 1'b1;
      res_q.chosen_group <= scan_grp_q;
      res_q.chosen_slot  <= SlotW'(idx_q);
    end else if (cmd_i.miss) begin
      res_q <= '0;
    end
  end

  assign out_data_o = res_q;

endmodule

/* hw/rtl/grouped_round_robin_task_picker_unit.sv */
// After acceptance, an item first chooses the group, then the scan visits one slot
// at a time until it finds a live task; a stalled output holds the result word back;
// a tick with no live task ends after the group choice alone.
// The next item is taken only once the controller is back in idle after the result word
// is formed, so items never overlap; the serial scan visits up to 15 slots for group H.
// Reset is asynchronous and active low: current group H, all pointers 0, no word pending.
// ----------------------------------------------------------------------------
// Grouped round robin task picker
// Picks the next live task over groups A, B and H with per-group round robin.
// ----------------------------------------------------------------------------
`include "grouped_round_robin_task_picker_unit_macros.svh"

module grouped_round_robin_task_picker_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  grrtp_pkg::grrtp_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output grrtp_pkg::grrtp_out_t out_data_o
);
  import grrtp_pkg::*;

  grrtp_cmd_t cmd;
  grrtp_sts_t sts;

  grrtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grrtp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  `GRRTP_ASSERT_NOW(a_player_slot_range, clk_i, rst_ni,
    out_valid_o && out_data_o.found && out_data_o.chosen_group != GrpH,
    out_data_o.chosen_slot < SlotW'(PlayerSlots))
  `GRRTP_ASSERT_NOW(a_miss_word_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.found,
    out_data_o.chosen_group == '0 && out_data_o.chosen_slot == '0)
  `GRRTP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && !in_stall_o, in_stall_o)

endmodule
